>>> hw/rtl/sorted_list_insert_delete_top_defines.svh
// Assertion macros for the sorted list block and its checker.
// No dependencies; included by the checker file.
`ifndef SORTED_LIST_INSERT_DELETE_TOP_DEFINES_SVH
`define SORTED_LIST_INSERT_DELETE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, held off during reset.
`define SLID_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, held off during reset.
`define SLID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/slid_pkg.sv
// Types and codes shared by the sorted list block.
// No dependencies.
package slid_pkg;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_DELETE = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_e;

  typedef struct packed {
    mode_e              mode;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    status_e    status;
    logic [4:0] count;
  } out_item_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic               ins;
    logic               del;
    logic signed [31:0] key;
  } cell_ctrl_t;

  // What one cell shows its neighbours.
  typedef struct packed {
    logic               valid;
    logic signed [31:0] entry;
    logic               gt;  // empty or holds a value above the key
    logic               ge;  // holds a value at or above the key
  } cell_link_t;

endpackage

>>> hw/rtl/sorted_list_insert_delete_top.sv
// Sorted table with insert and delete, built as a chain of compare-and-shift cells.
// Result: registered, offered in the cycle after the input transaction is accepted.
// Throughput: one per cycle unless stalled; all cells compare and shift at once.
// Reset: asynchronous, active low; empties the table and drops any pending result.
// Depends on slid_pkg and slid_cell.
module sorted_list_insert_delete_top #(
  parameter int unsigned TableDepth = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  slid_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output slid_pkg::out_item_t out_data_o
);
  import slid_pkg::*;

  localparam int unsigned CntW = $clog2(TableDepth + 1);

  logic [CntW-1:0]       count_q, count_d;
  logic [CntW+4:0]       count_ext;
  logic                  out_valid_q;
  out_item_t             out_q, out_d;
  logic                  accept, full, found;
  cell_ctrl_t            ctrl;
  cell_link_t            links [TableDepth];
  cell_link_t            prevs [TableDepth];
  cell_link_t            nexts [TableDepth];
  logic [TableDepth-1:0] hits;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(TableDepth));
  assign found      = |hits;

  assign ctrl.key = in_data_i.value;
  assign ctrl.ins = accept && (in_data_i.mode == MODE_INSERT) && !full;
  assign ctrl.del = accept && (in_data_i.mode == MODE_DELETE) && found;

  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prevs[i] = '{valid: 1'b1, entry: '0, gt: 1'b0, ge: 1'b0};
    end else begin : g_mid
      assign prevs[i] = links[i-1];
    end
    if (i == TableDepth - 1) begin : g_tail
      assign nexts[i] = '{valid: 1'b0, entry: '0, gt: 1'b1, ge: 1'b0};
    end else begin : g_body
      assign nexts[i] = links[i+1];
    end

    slid_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .prev_i (prevs[i]),
      .next_i (nexts[i]),
      .link_o (links[i]),
      .hit_o  (hits[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.del) begin
      count_d = count_q - CntW'(1);
    end
  end

  assign count_ext = {5'b0, count_d};

  always_comb begin
    out_d.count  = count_ext[4:0];
    out_d.status = ST_DONE;
    if (in_data_i.mode == MODE_INSERT) begin
      if (full) begin
        out_d.status = ST_FULL;
      end
    end else if (!found) begin
      out_d.status = ST_MISSING;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hw/rtl/slid_cell.sv
// One slot of the sorted table: holds an entry and shifts with its neighbours.
// Depends on slid_pkg.
module slid_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  slid_pkg::cell_ctrl_t ctrl_i,
  input  slid_pkg::cell_link_t prev_i,
  input  slid_pkg::cell_link_t next_i,
  output slid_pkg::cell_link_t link_o,
  output logic                hit_o
);
  import slid_pkg::*;

  logic               valid_q, valid_d;
  logic signed [31:0] entry_q, entry_d;
  logic               gt, ge;

  assign gt = !valid_q || (entry_q > ctrl_i.key);
  assign ge = valid_q && (entry_q >= ctrl_i.key);

  // first entry at or above the key and equal to it
  assign hit_o = valid_q && (entry_q == ctrl_i.key) && !prev_i.ge;

  assign link_o = '{valid: valid_q, entry: entry_q, gt: gt, ge: ge};

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (ctrl_i.ins && gt) begin
      valid_d = valid_q | prev_i.valid;
      entry_d = prev_i.gt ? prev_i.entry : ctrl_i.key;
    end else if (ctrl_i.del && ge) begin
      valid_d = next_i.valid;
      entry_d = next_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

>>> hw/rtl/slid_chk.sv
// Port-level checker for the sorted list block, bound to the top level.
// Depends on slid_pkg and sorted_list_insert_delete_top_defines.svh.
`include "sorted_list_insert_delete_top_defines.svh"

module slid_chk #(
  parameter int unsigned TableDepth = 16
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input slid_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input slid_pkg::out_item_t out_data_o
);
  import slid_pkg::*;

  logic [31:0] cnt32;
  logic        in_acc;
  logic        out_stall;

  assign cnt32     = {27'b0, out_data_o.count};
  assign in_acc    = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;

  `SLID_ASSERT_NEXT(a_result_follows, in_acc, out_valid_o, "no result after transaction")

  `SLID_ASSERT_NEXT(a_result_held, out_stall, out_valid_o && $stable(out_data_o), "stalled result changed")

  `SLID_ASSERT_NOW(a_full_count, out_valid_o && (out_data_o.status == ST_FULL) && (TableDepth < 32), cnt32 == TableDepth, "refused insert with table not full")

  `SLID_ASSERT_NOW(a_count_bound, out_valid_o && (TableDepth < 32), cnt32 <= TableDepth, "count above table depth")

endmodule

bind sorted_list_insert_delete_top slid_chk #(.TableDepth(TableDepth)) u_slid_chk (.*);
